/* design/nog_pkg.sv */
// Shared types and constants for the nonet/octet gearbox.
package nog_pkg;

    localparam logic [8:0] NONET_MASK = 9'h1FF;
    localparam logic [7:0] OCTET_MASK = 8'hFF;

    typedef enum logic [1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_START_SLACK = 2'd1,
        CFG_PRELOAD_OCTET = 2'd2
    } cfg_index_t;

    typedef logic signed [4:0] bit_count_t;

    typedef struct packed {
        logic [15:0] buffer;
        bit_count_t  count;
        logic        at_start;
    } stream_t;

    typedef struct packed {
        logic [8:0] value;
        logic       last;
    } beat_t;

    typedef struct packed {
        beat_t      first;
        beat_t      second;
        logic [1:0] num;
    } step_t;

    localparam stream_t STREAM_RESTART = '{buffer: 16'h0000, count: 5'sd0, at_start: 1'b1};

endpackage

/* design/nog_step.sv */
// Combinational step of the gearbox: next stream state and up to two result beats.
module nog_step
    import nog_pkg::*;
(
    input  stream_t     cur,
    input  logic        direction,
    input  logic [2:0]  start_slack,
    input  logic [7:0]  preload_octet,
    input  logic        kind,
    input  logic [8:0]  value,
    input  logic [7:0]  existing_octet,
    output stream_t     nxt,
    output step_t       res
);

    logic [15:0] pre16;
    logic [15:0] flush16;
    logic [7:0]  flush_octet;
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] sh;
    logic [5:0]  c0;
    logic [5:0]  c1;
    logic [5:0]  rest;

    always_comb
    begin
        pre16 = {8'h00, preload_octet} >> (4'd8 - {1'b0, start_slack});
        flush16 = {8'h00, cur.buffer[7:0]} << (4'd8 - {1'b0, cur.count[2:0]});
        flush_octet = (existing_octet & (OCTET_MASK >> cur.count[2:0])) | flush16[7:0];

        nxt = cur;
        res.first = '{value: 9'h000, last: 1'b1};
        res.second = '{value: 9'h000, last: 1'b1};
        res.num = 2'd0;
        b0 = cur.buffer;
        b1 = 16'h0000;
        sh = 16'h0000;
        c0 = {cur.count[4], cur.count};
        c1 = 6'd0;
        rest = 6'd0;

        if (!direction)
        begin
            if (kind)
            begin
                if (!cur.at_start && cur.count > 5'sd0 && cur.count < 5'sd8)
                begin
                    res.first = '{value: {1'b0, flush_octet}, last: 1'b1};
                    res.num = 2'd1;
                end
                nxt = STREAM_RESTART;
            end
            else
            begin
                if (cur.at_start)
                begin
                    c0 = {3'b000, start_slack};
                    b0 = pre16;
                end
                b1 = {b0[6:0], value};
                c1 = c0 + 6'd9;
                rest = c1 - 6'd8;
                sh = b1 >> rest[3:0];
                if (rest == 6'd8)
                begin
                    res.first = '{value: {1'b0, sh[7:0]}, last: 1'b0};
                    res.second = '{value: {1'b0, b1[7:0]}, last: 1'b1};
                    res.num = 2'd2;
                    nxt.count = 5'sd0;
                end
                else
                begin
                    res.first = '{value: {1'b0, sh[7:0]}, last: 1'b1};
                    res.num = 2'd1;
                    nxt.count = rest[4:0];
                end
                nxt.buffer = b1;
                nxt.at_start = 1'b0;
            end
        end
        else
        begin
            if (kind)
            begin
                nxt = STREAM_RESTART;
            end
            else
            begin
                if (cur.at_start)
                begin
                    c0 = 6'd0 - {3'b000, start_slack};
                    b0 = 16'h0000;
                end
                b1 = {b0[7:0], value[7:0]};
                c1 = c0 + 6'd8;
                rest = c1 - 6'd9;
                sh = b1 >> rest[3:0];
                if ($signed(c1) >= 6'sd9)
                begin
                    res.first = '{value: sh[8:0] & NONET_MASK, last: 1'b1};
                    res.num = 2'd1;
                    nxt.count = rest[4:0];
                end
                else
                begin
                    nxt.count = c1[4:0];
                end
                nxt.buffer = b1;
                nxt.at_start = 1'b0;
            end
        end
    end

endmodule

/* design/nonet_octet_gearbox.sv */
// Top level of the nonet/octet gearbox: configuration, stream state and result stage.
// The gearbox takes one input beat per clock while in_stall is low and shows its
// results in the cycle after acceptance from a two-entry result register. Each result
// beat leaves on its own cycle, so a packed nonet that completes two octets (one in
// every eight in steady state) keeps the input stalled until its first octet has
// left; otherwise the rate is one item per clock when out_stall is low, limited by
// the single result port. Configuration writes take effect at the next stream
// start, except that a write to the direction register restarts the stream at once.
module nonet_octet_gearbox
    import nog_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [8:0] value,
    input  logic [7:0] existing_octet,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [8:0] out_value,
    output logic       last
);

    logic       direction_reg;
    logic [2:0] start_slack_reg;
    logic [7:0] preload_octet_reg;
    stream_t    stream_reg;
    stream_t    stream_next;
    step_t      step_res;
    beat_t      slot0_reg;
    beat_t      slot1_reg;
    logic [1:0] rem_reg;
    logic       in_fire;
    logic       out_fire;

    nog_step u_step (
        .cur            (stream_reg),
        .direction      (direction_reg),
        .start_slack    (start_slack_reg),
        .preload_octet  (preload_octet_reg),
        .kind           (kind),
        .value          (value),
        .existing_octet (existing_octet),
        .nxt            (stream_next),
        .res            (step_res)
    );

    assign out_valid = (rem_reg != 2'd0);
    assign out_value = slot0_reg.value;
    assign last = slot0_reg.last;
    assign in_stall = (rem_reg == 2'd2) || (rem_reg == 2'd1 && out_stall);
    assign in_fire = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            start_slack_reg <= 3'd0;
            preload_octet_reg <= 8'h00;
            stream_reg <= STREAM_RESTART;
            rem_reg <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_DIRECTION:     direction_reg <= cfg_data[0];
                    CFG_START_SLACK:   start_slack_reg <= cfg_data[2:0];
                    CFG_PRELOAD_OCTET: preload_octet_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cfg_wr_en && cfg_index == CFG_DIRECTION)
            begin
                stream_reg <= STREAM_RESTART;
            end
            else if (in_fire)
            begin
                stream_reg <= stream_next;
            end
            if (in_fire)
            begin
                rem_reg <= step_res.num;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot0_reg <= step_res.first;
            slot1_reg <= step_res.second;
        end
        else if (out_fire && rem_reg == 2'd2)
        begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef ASSERT_OFF
    // The first of two buffered beats is never the final one for its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd2) |-> !slot0_reg.last)
        else $error("first of two result beats is marked last");

    // A packed data nonet always yields at least one octet in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !direction_reg && !kind && !cfg_wr_en) |=> out_valid)
        else $error("packed nonet produced no octet");

    // The bit count stays within the range the shifter supports.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream_reg.count <= 5'sd8 && stream_reg.count >= -5'sd7))
        else $error("bit count out of range");

    // A result stage holding two beats never accepts another item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd2) |-> !in_fire)
        else $error("item accepted while two beats are pending");
`endif

endmodule
